>>> rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ACLA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acla: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ACLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acla: assertion failed");

`endif

>>> rtl/acla_pkg.sv
// Shared constants, command/status types and helpers for the ambient cube light block.
// No dependencies; used by every RTL module of the block except the checker acla_chk.
package acla_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_FACES = 7;
    localparam int FACE_AMB  = 6;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_DIR   = 2'd1;
    localparam logic [1:0] MODE_DYN   = 2'd2;
    localparam logic [1:0] MODE_EVAL  = 2'd3;

    localparam logic [63:0]        ONE_64        = 64'd1 << FRAC_BITS;
    localparam logic signed [31:0] THREE_ONE     = 32'(3 * (64'd1 << FRAC_BITS));
    localparam logic signed [31:0] FALLOFF_SCALE = 32'sd765;

    localparam logic [6:0] DSU_DIV_STEPS  = 7'd64;
    localparam logic [6:0] DSU_SQRT_STEPS = 7'd32;

    // datapath operations
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_CLEAR     = 5'd2;
    localparam logic [4:0] OP_MUL_DIR   = 5'd3;
    localparam logic [4:0] OP_ACC_SPLIT = 5'd4;
    localparam logic [4:0] OP_AMB       = 5'd5;
    localparam logic [4:0] OP_MUL_EVAL  = 5'd6;
    localparam logic [4:0] OP_ACC_EVAL  = 5'd7;
    localparam logic [4:0] OP_OUT       = 5'd8;
    localparam logic [4:0] OP_MUL_SQ    = 5'd9;
    localparam logic [4:0] OP_ACC_SQ    = 5'd10;
    localparam logic [4:0] OP_MUL_DEN   = 5'd11;
    localparam logic [4:0] OP_DIV_Y2    = 5'd12;
    localparam logic [4:0] OP_Y2        = 5'd13;
    localparam logic [4:0] OP_MUL_Y2SQ  = 5'd14;
    localparam logic [4:0] OP_MUL_P     = 5'd15;
    localparam logic [4:0] OP_INT       = 5'd16;
    localparam logic [4:0] OP_MUL_SCL   = 5'd17;
    localparam logic [4:0] OP_AMT       = 5'd18;
    localparam logic [4:0] OP_SQRT      = 5'd19;
    localparam logic [4:0] OP_RAD       = 5'd20;
    localparam logic [4:0] OP_DIV_N     = 5'd21;
    localparam logic [4:0] OP_NN        = 5'd22;
    localparam logic [4:0] OP_MUL_NN    = 5'd23;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] ax;
    } t_dp_cmd;

    typedef struct packed {
        logic lvl_zero;   // level or falloff is zero
        logic y2_big;     // falloff parameter beyond one
        logic amt_zero;   // dynamic amount is zero
        logic sum_zero;   // offset length is zero
        logic dsu_busy;   // divide/sqrt unit working
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -72'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

>>> rtl/acla_dsu.sv
// Shared iterative divide / square-root unit: one quotient bit or one root bit per cycle.
// Depends on acla_pkg.
module acla_dsu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic [63:0] o_quo,
    output logic [65:0] o_rem,
    output logic [31:0] o_root
);
    import acla_pkg::*;

    logic [65:0] r_acc;
    logic [63:0] r_q;
    logic [63:0] r_b;
    logic [31:0] r_root;
    logic [6:0]  r_cnt;
    logic        r_sqrt;

    logic [65:0] sh;
    logic [65:0] trial;
    logic        ge;

    always_comb begin
        if (r_sqrt) begin
            sh    = {r_acc[63:0], r_q[63:62]};
            trial = {32'd0, r_root, 2'b01};
        end else begin
            sh    = {r_acc[64:0], r_q[63]};
            trial = 66'(r_b);
        end
        ge = (sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_sqrt ? DSU_SQRT_STEPS : DSU_DIV_STEPS;
        end else if (r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_q    <= i_a;
            r_b    <= i_b;
            r_root <= '0;
            r_sqrt <= i_sqrt;
        end else if (r_cnt != 7'd0) begin
            r_acc <= ge ? (sh - trial) : sh;
            if (r_sqrt) begin
                r_q    <= {r_q[61:0], 2'b00};
                r_root <= {r_root[30:0], ge};
            end else begin
                r_q <= {r_q[62:0], ge};
            end
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quo  = r_q;
    assign o_rem  = r_acc;
    assign o_root = r_root;

endmodule

>>> rtl/acla_datapath.sv
// Datapath: light vector, shared 32x32 multiplier, falloff chain and output register.
// Depends on acla_pkg and acla_dsu; driven by commands from acla_ctrl.
module acla_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acla_pkg::t_dp_cmd     i_cmd,
    output acla_pkg::t_dp_stat    o_stat,
    input  logic signed [31:0]    i_vec_x,
    input  logic signed [31:0]    i_vec_y,
    input  logic signed [31:0]    i_vec_z,
    input  logic signed [31:0]    i_direct_amount,
    input  logic signed [31:0]    i_ambient_amount,
    input  logic signed [31:0]    i_light_level,
    input  logic [30:0]           i_light_falloff,
    output logic signed [31:0]    o_direct_light,
    output logic signed [31:0]    o_ambient_light,
    output logic signed [31:0]    o_total_light
);
    import acla_pkg::*;

    logic signed [31:0] r_vec [NUM_FACES];
    logic signed [31:0] r_n [3];
    logic signed [31:0] r_direct;
    logic signed [31:0] r_ambient;
    logic signed [31:0] r_level;
    logic [30:0]        r_falloff;
    logic signed [63:0] r_prod;
    logic               r_pos;
    logic               r_neg;
    logic signed [51:0] r_dir;
    logic [63:0]        r_sxy;
    logic [63:0]        r_sall;
    logic [63:0]        r_den;
    logic [31:0]        r_y2;
    logic               r_big;
    logic signed [63:0] r_t;
    logic [31:0]        r_inten;
    logic signed [63:0] r_scaled;
    logic signed [31:0] r_amount;
    logic [31:0]        r_rad;
    logic signed [31:0] r_nn;
    logic signed [31:0] r_out_dir;
    logic signed [31:0] r_out_amb;
    logic signed [31:0] r_out_tot;

    logic signed [31:0] n_sel;
    logic signed [63:0] n_ext;
    logic [63:0]        mag;
    logic [2:0]         face_idx;
    logic signed [31:0] face;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] prod_sh;
    logic signed [71:0] split_sum;
    logic signed [31:0] dir_sat;
    logic [63:0]        y2_full;
    logic [66:0]        rem2;
    logic signed [71:0] amt_wide;

    logic               dsu_start;
    logic               dsu_sqrt;
    logic [63:0]        dsu_a;
    logic [63:0]        dsu_b;
    logic               dsu_busy;
    logic [63:0]        dsu_quo;
    logic [65:0]        dsu_rem;
    logic [31:0]        dsu_root;

    assign n_sel    = r_n[i_cmd.ax];
    assign n_ext    = 64'(n_sel);
    assign mag      = n_sel[31] ? 64'(-n_ext) : 64'(n_ext);
    assign face_idx = (i_cmd.op == OP_MUL_EVAL) ? {i_cmd.ax, n_sel[31]} : {i_cmd.ax, r_neg};
    assign face     = r_vec[face_idx];
    assign prod_sh  = r_prod >>> FRAC_BITS;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_DIR: begin
                mul_a = n_sel;
                mul_b = r_direct;
            end
            OP_MUL_EVAL: begin
                mul_a = n_sel;
                mul_b = face;
            end
            OP_MUL_SQ: begin
                mul_a = n_sel;
                mul_b = n_sel;
            end
            OP_MUL_DEN: begin
                mul_a = FALLOFF_SCALE;
                mul_b = $signed({1'b0, r_falloff});
            end
            OP_MUL_Y2SQ: begin
                mul_a = $signed(r_y2);
                mul_b = $signed(r_y2);
            end
            OP_MUL_P: begin
                mul_a = $signed(r_y2);
                mul_b = THREE_ONE - r_t[31:0];
            end
            OP_MUL_SCL: begin
                mul_a = $signed(r_inten);
                mul_b = r_level;
            end
            OP_MUL_NN: begin
                mul_a = r_nn;
                mul_b = r_amount;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign split_sum = r_neg ? (72'(face) - 72'(prod_sh)) : (72'(face) + 72'(prod_sh));
    assign dir_sat   = sat32(72'(r_dir));
    assign rem2      = {dsu_rem, 1'b0};
    assign y2_full   = {dsu_quo[62:0], 1'b0} | 64'(rem2 >= 67'(r_den));
    assign amt_wide  = (72'(r_scaled) <<< 8) - 72'(r_scaled);

    // divide/sqrt operand selection
    always_comb begin
        dsu_start = 1'b0;
        dsu_sqrt  = 1'b0;
        dsu_a     = r_sxy;
        dsu_b     = r_den;
        case (i_cmd.op)
            OP_DIV_Y2: begin
                dsu_start = 1'b1;
            end
            OP_SQRT: begin
                dsu_start = 1'b1;
                dsu_sqrt  = 1'b1;
                dsu_a     = r_sall;
            end
            OP_DIV_N: begin
                dsu_start = 1'b1;
                dsu_a     = mag << FRAC_BITS;
                dsu_b     = 64'(r_rad);
            end
            default: begin
                dsu_start = 1'b0;
            end
        endcase
    end

    acla_dsu u_dsu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dsu_start),
        .i_sqrt  (dsu_sqrt),
        .i_a     (dsu_a),
        .i_b     (dsu_b),
        .o_busy  (dsu_busy),
        .o_quo   (dsu_quo),
        .o_rem   (dsu_rem),
        .o_root  (dsu_root)
    );

    // light vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == OP_CLEAR) begin
            for (int i = 0; i < NUM_FACES; i++) begin
                r_vec[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_ACC_SPLIT: begin
                    if (r_pos || r_neg) begin
                        r_vec[face_idx] <= sat32(split_sum);
                    end
                end
                OP_AMB: begin
                    r_vec[FACE_AMB] <= sat32(72'(r_vec[FACE_AMB]) + 72'(r_ambient));
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_n[0]    <= i_vec_x;
                r_n[1]    <= i_vec_y;
                r_n[2]    <= i_vec_z;
                r_direct  <= i_direct_amount;
                r_ambient <= i_ambient_amount;
                r_level   <= i_light_level;
                r_falloff <= i_light_falloff;
                r_dir     <= '0;
                r_sxy     <= '0;
                r_sall    <= '0;
            end
            OP_MUL_DIR, OP_MUL_EVAL: begin
                r_prod <= mul_p;
                r_pos  <= (n_sel > 32'sd0);
                r_neg  <= n_sel[31];
            end
            OP_MUL_NN: begin
                r_prod <= mul_p;
                r_pos  <= (r_nn > 32'sd0);
                r_neg  <= r_nn[31];
            end
            OP_ACC_EVAL: begin
                r_dir <= r_neg ? (r_dir - 52'(prod_sh)) : (r_dir + 52'(prod_sh));
            end
            OP_OUT: begin
                r_out_dir <= dir_sat;
                r_out_amb <= r_vec[FACE_AMB];
                r_out_tot <= sat32(72'(dir_sat) + 72'(r_vec[FACE_AMB]));
            end
            OP_MUL_SQ: begin
                r_prod <= mul_p;
            end
            OP_ACC_SQ: begin
                r_sall <= r_sall + 64'(r_prod);
                if (i_cmd.ax != 2'd2) begin
                    r_sxy <= r_sxy + 64'(r_prod);
                end
            end
            OP_MUL_DEN: begin
                r_den <= 64'(mul_p);
            end
            OP_Y2: begin
                r_y2  <= y2_full[31:0];
                r_big <= (y2_full > ONE_64);
            end
            OP_MUL_Y2SQ: begin
                r_t <= mul_p >>> FRAC_BITS;
            end
            OP_MUL_P: begin
                r_t <= mul_p >>> (FRAC_BITS + 1);
            end
            OP_INT: begin
                r_inten <= (64'(r_t) >= ONE_64) ? 32'd0 : 32'(ONE_64 - 64'(r_t));
            end
            OP_MUL_SCL: begin
                r_scaled <= mul_p >>> FRAC_BITS;
            end
            OP_AMT: begin
                r_amount <= sat32(amt_wide);
            end
            OP_RAD: begin
                r_rad <= dsu_root;
            end
            OP_NN: begin
                r_nn <= n_sel[31] ? -$signed(dsu_quo[31:0]) : $signed(dsu_quo[31:0]);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.lvl_zero = (r_level == 32'sd0) || (r_falloff == 31'd0);
    assign o_stat.y2_big   = r_big;
    assign o_stat.amt_zero = (r_amount == 32'sd0);
    assign o_stat.sum_zero = (r_sall == 64'd0);
    assign o_stat.dsu_busy = dsu_busy;

    assign o_direct_light  = r_out_dir;
    assign o_ambient_light = r_out_amb;
    assign o_total_light   = r_out_tot;

endmodule

>>> rtl/acla_ctrl.sv
// Controller state machine: sequences the datapath per item and owns the handshakes.
// Depends on acla_pkg.
module acla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    input  logic               i_stall,
    input  acla_pkg::t_dp_stat i_stat,
    output acla_pkg::t_dp_cmd  o_cmd,
    output logic               o_stall,
    output logic               o_valid
);
    import acla_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_DMUL  = 5'd2;
    localparam logic [4:0] S_DACC  = 5'd3;
    localparam logic [4:0] S_AMB   = 5'd4;
    localparam logic [4:0] S_EMUL  = 5'd5;
    localparam logic [4:0] S_EACC  = 5'd6;
    localparam logic [4:0] S_OUT   = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_SMUL  = 5'd9;
    localparam logic [4:0] S_SACC  = 5'd10;
    localparam logic [4:0] S_DEN   = 5'd11;
    localparam logic [4:0] S_DIV1  = 5'd12;
    localparam logic [4:0] S_DIV1W = 5'd13;
    localparam logic [4:0] S_Y2    = 5'd14;
    localparam logic [4:0] S_Y2SQ  = 5'd15;
    localparam logic [4:0] S_P     = 5'd16;
    localparam logic [4:0] S_INT   = 5'd17;
    localparam logic [4:0] S_SCL   = 5'd18;
    localparam logic [4:0] S_AMT   = 5'd19;
    localparam logic [4:0] S_SQRT  = 5'd20;
    localparam logic [4:0] S_SQW   = 5'd21;
    localparam logic [4:0] S_RAD   = 5'd22;
    localparam logic [4:0] S_NDIV  = 5'd23;
    localparam logic [4:0] S_NDIVW = 5'd24;
    localparam logic [4:0] S_NN    = 5'd25;
    localparam logic [4:0] S_NMUL  = 5'd26;
    localparam logic [4:0] S_NACC  = 5'd27;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [1:0] r_ax;
    logic [1:0] n_ax;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_ax     = r_ax;
        o_cmd.op = OP_NONE;
        o_cmd.ax = r_ax;
        n_ovalid = r_ovalid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_ax     = 2'd0;
                    unique case (i_mode)
                        MODE_CLEAR: n_state = S_CLR;
                        MODE_DIR:   n_state = S_DMUL;
                        MODE_DYN:   n_state = S_CHK;
                        MODE_EVAL:  n_state = S_EMUL;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_IDLE;
            end
            S_DMUL: begin
                o_cmd.op = OP_MUL_DIR;
                n_state  = S_DACC;
            end
            S_DACC: begin
                o_cmd.op = OP_ACC_SPLIT;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_AMB;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_DMUL;
                end
            end
            S_AMB: begin
                o_cmd.op = OP_AMB;
                n_state  = S_IDLE;
            end
            S_EMUL: begin
                o_cmd.op = OP_MUL_EVAL;
                n_state  = S_EACC;
            end
            S_EACC: begin
                o_cmd.op = OP_ACC_EVAL;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_OUT;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_EMUL;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CHK: begin
                n_state = i_stat.lvl_zero ? S_IDLE : S_SMUL;
            end
            S_SMUL: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_SACC;
            end
            S_SACC: begin
                o_cmd.op = OP_ACC_SQ;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_DEN;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_SMUL;
                end
            end
            S_DEN: begin
                o_cmd.op = OP_MUL_DEN;
                n_state  = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.op = OP_DIV_Y2;
                n_state  = S_DIV1W;
            end
            S_DIV1W: begin
                if (!i_stat.dsu_busy) begin
                    n_state = S_Y2;
                end
            end
            S_Y2: begin
                o_cmd.op = OP_Y2;
                n_state  = S_Y2SQ;
            end
            S_Y2SQ: begin
                if (i_stat.y2_big) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_MUL_Y2SQ;
                    n_state  = S_P;
                end
            end
            S_P: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_INT;
            end
            S_INT: begin
                o_cmd.op = OP_INT;
                n_state  = S_SCL;
            end
            S_SCL: begin
                o_cmd.op = OP_MUL_SCL;
                n_state  = S_AMT;
            end
            S_AMT: begin
                o_cmd.op = OP_AMT;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                if (i_stat.amt_zero || i_stat.sum_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_SQRT;
                    n_state  = S_SQW;
                end
            end
            S_SQW: begin
                if (!i_stat.dsu_busy) begin
                    n_state = S_RAD;
                end
            end
            S_RAD: begin
                o_cmd.op = OP_RAD;
                n_state  = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.op = OP_DIV_N;
                n_state  = S_NDIVW;
            end
            S_NDIVW: begin
                if (!i_stat.dsu_busy) begin
                    n_state = S_NN;
                end
            end
            S_NN: begin
                o_cmd.op = OP_NN;
                n_state  = S_NMUL;
            end
            S_NMUL: begin
                o_cmd.op = OP_MUL_NN;
                n_state  = S_NACC;
            end
            S_NACC: begin
                o_cmd.op = OP_ACC_SPLIT;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = S_IDLE;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_NDIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ax     <= n_ax;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

>>> rtl/ambient_cube_light_accumulate.sv
// Ambient cube light accumulator: keeps a seven-entry light vector (+X, -X, +Y, -Y, +Z, -Z
// faces and an ambient term) in signed Q16.16 and works one item at a time. Mode 0 clears
// the vector. Mode 1 splits the direct amount over the faces picked by the sign of each
// normal component and adds the ambient amount. Mode 3 evaluates the vector for a normal
// and gives one result item with direct, ambient and saturated total light, waiting for
// the output register to empty if needed. Mode 2 adds a dynamic light: squared lengths, a
// 64-step division for the falloff parameter, the falloff polynomial, a 32-step square
// root and one 64-step division per axis to normalize the offset; it ends early when the
// light is out of range or when level or falloff is zero. The division and square root
// share one iterative unit that produces one bit per cycle. A finished result sits in an
// output register, so the next item is accepted while that result waits. All stores into
// the vector and all outputs saturate to the signed 32-bit range.
// Depends on acla_pkg, acla_ctrl, acla_datapath (and acla_dsu below it).
module ambient_cube_light_accumulate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_direct_amount,
    input  logic signed [31:0] i_ambient_amount,
    input  logic signed [31:0] i_light_level,
    input  logic [30:0]        i_light_falloff,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_direct_light,
    output logic signed [31:0] o_ambient_light,
    output logic signed [31:0] o_total_light
);
    import acla_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: one state per datapath step, loops over the three axes
    acla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // vector storage, multiplier, falloff math, divide/sqrt unit, output register
    acla_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_vec_x          (i_vec_x),
        .i_vec_y          (i_vec_y),
        .i_vec_z          (i_vec_z),
        .i_direct_amount  (i_direct_amount),
        .i_ambient_amount (i_ambient_amount),
        .i_light_level    (i_light_level),
        .i_light_falloff  (i_light_falloff),
        .o_direct_light   (o_direct_light),
        .o_ambient_light  (o_ambient_light),
        .o_total_light    (o_total_light)
    );

endmodule

>>> rtl/acla_chk.sv
// Port-level checker for the ambient cube light block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module acla_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_direct_light,
    input logic signed [31:0] o_ambient_light,
    input logic signed [31:0] o_total_light
);
    logic signed [32:0] w_sum;
    logic signed [31:0] w_exp;
    logic [95:0]        w_out;

    assign w_sum = 33'(o_direct_light) + 33'(o_ambient_light);
    assign w_exp = (w_sum[32] != w_sum[31]) ? (w_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                            : w_sum[31:0];
    assign w_out = {o_direct_light, o_ambient_light, o_total_light};

    // a waiting result holds
    `ACLA_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_out))
    // an accepted item makes the input busy in the next cycle
    `ACLA_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    // no result can appear the cycle right after an item is taken
    `ACLA_ASSERT_NEXT(a_no_instant_result, i_valid && !o_stall, !$rose(o_valid))
    // total is the saturated sum of direct and ambient
    `ACLA_ASSERT_NOW(a_total_sum, o_valid, o_total_light == w_exp)

endmodule

bind ambient_cube_light_accumulate acla_chk u_acla_chk (.*);
